// ===== rtl/core/shnk_pkg.sv =====
//------------------------------------------------------------------------------
// shnk_pkg
// Shared types and constants of the spatial hash neighbor key unit.
//------------------------------------------------------------------------------
package shnk_pkg;

    localparam int NumAxes   = 3;
    localparam int PosW      = 32;
    localparam int CellW     = 31;
    localparam int ResW      = 11;
    localparam int IdxW      = 11;
    localparam int KeyW      = 30;
    localparam int CornerW   = 3;
    localparam int MaxRes    = 1024;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 32;
    localparam int DivSteps  = 33;

    localparam logic [CfgIdxW-1:0] RegDims = 3'd0;
    localparam logic [CfgIdxW-1:0] RegCell = 3'd1;
    localparam logic [CfgIdxW-1:0] RegResX = 3'd2;
    localparam logic [CfgIdxW-1:0] RegResY = 3'd3;
    localparam logic [CfgIdxW-1:0] RegResZ = 3'd4;

    typedef struct packed {
        logic              three_d;
        logic [CellW-1:0]  cell_size;
        logic [ResW-1:0]   res_x;
        logic [ResW-1:0]   res_y;
        logic [ResW-1:0]   res_z;
    } t_cfg;

    // Wrapped bucket index of one axis and of its neighbor.
    typedef struct packed {
        logic [IdxW-1:0] base;
        logic [IdxW-1:0] nbr;
    } t_axis;

    typedef struct packed {
        t_axis [NumAxes-1:0] ax;
        logic                three_d;
    } t_keyset;

endpackage

// ===== rtl/core/shnk_axis_div.sv =====
//------------------------------------------------------------------------------
// shnk_axis_div
// Pipelined restoring divider per axis: floor bucket index, half-cell
// direction and wrap of both candidate indexes into the axis resolution.
//------------------------------------------------------------------------------
module shnk_axis_div
    import shnk_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [NumAxes*PosW-1:0] i_pos,
    input  t_cfg                   i_cfg,
    output logic                   o_valid,
    output t_keyset                o_keys
);

    localparam int DW = PosW + 1;
    localparam int RemW = CellW + 1;
    localparam int NS = DivSteps;

    // Pipeline: stage 0 captures offset dividend, stages 1..NS do one quotient
    // bit each, then a fix stage, a wrap stage and an output register. The
    // quotient is reduced modulo the resolution one bit behind the divider.
    logic [NS+3:0]                        r_vld;
    logic [NumAxes-1:0][DW-1:0]           r_dvd   [NS+1];
    logic [NumAxes-1:0][RemW-1:0]         r_rem   [NS+1];
    logic [NumAxes-1:0][ResW-1:0]         r_mod   [NS+1];
    logic [NumAxes-1:0]                   r_neg   [NS+1];
    logic [CellW-1:0]                     r_c     [NS+1];
    logic [ResW-1:0]                      r_res   [NS+4][NumAxes];
    logic                                 r_3d    [NS+4];

    logic [NumAxes-1:0][IdxW+1:0]         r_qa;
    logic [NumAxes-1:0][IdxW+1:0]         r_qb;
    logic [NumAxes-1:0][IdxW+1:0]         r_wa;
    logic [NumAxes-1:0][IdxW+1:0]         r_wb;
    t_keyset                              r_out;

    logic [CellW-1:0] n_c;
    assign n_c = (i_cfg.cell_size == '0) ? CellW'(1) : i_cfg.cell_size;

    function automatic logic [ResW-1:0] clamp_res(input logic [ResW-1:0] r);
        logic [ResW-1:0] v;
        v = r;
        if (r == '0) begin
            v = ResW'(1);
        end else if (r > ResW'(MaxRes)) begin
            v = ResW'(MaxRes);
        end
        return v;
    endfunction

    // One step of the running remainder: (2 * m + b) mod n, with m < n.
    function automatic logic [ResW-1:0] mod_step(input logic [ResW-1:0] m,
                                                 input logic            b,
                                                 input logic [ResW-1:0] n);
        logic [ResW:0] t;
        t = {m, b};
        if (t >= (ResW+1)'(n)) begin
            t = t - (ResW+1)'(n);
        end
        return ResW'(t);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS+2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Negative a: floor(a/c) = -(((-a-1)/c)+1), remainder c-1-r'.
            for (int a = 0; a < NumAxes; a++) begin
                logic signed [DW-1:0] s;
                s = DW'(signed'(i_pos[a*PosW +: PosW]));
                r_neg[0][a] <= s[DW-1];
                r_dvd[0][a] <= s[DW-1] ? ~s : s;
                r_rem[0][a] <= '0;
                r_mod[0][a] <= '0;
            end
            r_c[0]      <= n_c;
            r_res[0][0] <= clamp_res(i_cfg.res_x);
            r_res[0][1] <= clamp_res(i_cfg.res_y);
            r_res[0][2] <= clamp_res(i_cfg.res_z);
            r_3d[0]     <= i_cfg.three_d;
            for (int s = 1; s <= NS; s++) begin
                for (int a = 0; a < NumAxes; a++) begin
                    logic [RemW:0] t;
                    t = {r_rem[s-1][a], r_dvd[s-1][a][DW-1]};
                    if (t >= (RemW+1)'(r_c[s-1])) begin
                        r_rem[s][a] <= RemW'(t - (RemW+1)'(r_c[s-1]));
                        r_dvd[s][a] <= {r_dvd[s-1][a][DW-2:0], 1'b1};
                    end else begin
                        r_rem[s][a] <= RemW'(t);
                        r_dvd[s][a] <= {r_dvd[s-1][a][DW-2:0], 1'b0};
                    end
                    r_mod[s][a] <= mod_step(r_mod[s-1][a],
                                            (s > 1) && r_dvd[s-1][a][0],
                                            r_res[s-1][a]);
                end
                r_neg[s] <= r_neg[s-1];
                r_c[s]   <= r_c[s-1];
            end
            for (int s = 1; s < NS+4; s++) begin
                r_res[s] <= r_res[s-1];
                r_3d[s]  <= r_3d[s-1];
            end
            // Fix stage: quotient mod res and both candidates, before the neighbor wrap.
            for (int a = 0; a < NumAxes; a++) begin
                logic [RemW-1:0]  r;
                logic [RemW:0]    rr;
                logic [IdxW+1:0]  qm;
                logic [IdxW+1:0]  rs;
                logic             up;
                r  = r_neg[NS][a] ? RemW'(RemW'(r_c[NS]) - 1'b1 - r_rem[NS][a])
                                  : r_rem[NS][a];
                rr = {r, 1'b0};
                up = rr >= (RemW+1)'(r_c[NS]);
                rs = (IdxW+2)'(r_res[NS][a]);
                // The last quotient bit completes the running remainder.
                qm = (IdxW+2)'(mod_step(r_mod[NS][a], r_dvd[NS][a][0], r_res[NS][a]));
                if (r_neg[NS][a]) begin
                    // floor = -(q+1); wrapped = res-1-(q mod res)
                    qm = rs - 1'b1 - qm;
                end
                r_qa[a] <= qm;
                r_qb[a] <= up ? qm + 1'b1 : qm + rs - 1'b1;
            end
            for (int a = 0; a < NumAxes; a++) begin
                logic [IdxW+1:0] rs;
                rs = (IdxW+2)'(r_res[NS+1][a]);
                r_wa[a] <= r_qa[a];
                r_wb[a] <= (r_qb[a] >= rs) ? r_qb[a] - rs : r_qb[a];
            end
            for (int a = 0; a < NumAxes; a++) begin
                r_out.ax[a].base <= IdxW'(r_wa[a]);
                r_out.ax[a].nbr  <= IdxW'(r_wb[a]);
            end
            r_out.three_d <= r_3d[NS+2];
        end
    end

    assign o_valid = r_vld[NS+3];
    assign o_keys  = r_out;

endmodule

// ===== rtl/core/shnk_key_seq.sv =====
//------------------------------------------------------------------------------
// shnk_key_seq
// Corner sequencer: linearizes one corner key per cycle unless stalled, with a
// registered multiply-add pair and drives the registered result stream.
//------------------------------------------------------------------------------
module shnk_key_seq
    import shnk_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_keyset            i_keys,
    input  logic [ResW-1:0]    i_res_x,
    input  logic [ResW-1:0]    i_res_y,
    output logic               o_busy,
    output logic               o_valid,
    output logic [KeyW-1:0]    o_key,
    output logic [CornerW-1:0] o_corner,
    output logic               o_last,
    input  logic               i_ready
);

    logic               r_act;
    t_keyset            r_set;
    logic [CornerW-1:0] r_j;
    logic               r_v1;
    logic [2*IdxW-1:0]  r_zy;
    logic [IdxW-1:0]    r_x1;
    logic [CornerW-1:0] r_j1;
    logic               r_l1;
    logic               r_ov;
    logic [KeyW-1:0]    r_key;
    logic [CornerW-1:0] r_cor;
    logic               r_last;
    logic               adv;
    logic               lastj;
    logic [IdxW-1:0]    wx, wy, wz;

    assign adv   = !r_ov || i_ready;
    assign lastj = r_set.three_d ? (r_j == 3'd7) : (r_j == 3'd3);
    assign o_busy = !adv || (r_act && !lastj);
    assign wx = r_j[0] ? r_set.ax[0].nbr : r_set.ax[0].base;
    assign wy = r_j[1] ? r_set.ax[1].nbr : r_set.ax[1].base;
    assign wz = (r_j[2] && r_set.three_d) ? r_set.ax[2].nbr
              : (r_set.three_d ? r_set.ax[2].base : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_v1  <= 1'b0;
            r_ov  <= 1'b0;
            r_j   <= '0;
        end else if (adv) begin
            r_v1 <= r_act;
            r_ov <= r_v1;
            if (r_act && !lastj) begin
                r_j <= r_j + 1'b1;
            end else if (i_valid) begin
                r_act <= 1'b1;
                r_j   <= '0;
            end else begin
                r_act <= 1'b0;
                r_j   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (!(r_act && !lastj) && i_valid) begin
                r_set <= i_keys;
            end
            r_zy  <= (2*IdxW)'(wz) * (2*IdxW)'(i_res_y) + (2*IdxW)'(wy);
            r_x1  <= wx;
            r_j1  <= r_j;
            r_l1  <= lastj;
            r_key <= KeyW'((3*IdxW)'(r_zy) * (3*IdxW)'(i_res_x) + (3*IdxW)'(r_x1));
            r_cor <= r_j1;
            r_last <= r_l1;
        end
    end

    assign o_valid  = r_ov;
    assign o_key    = r_key;
    assign o_corner = r_cor;
    assign o_last   = r_last;

endmodule

// ===== rtl/core/spatial_hash_neighbor_keys_unit.sv =====
// Each accepted position yields four keys (2-D) or eight keys (3-D), one key
// per cycle while the result channel is not stalled, so a position takes four
// or eight transfers of the result channel; the sequencer sets that rate. The
// first key passes a capture stage, 33 divider stages of one quotient bit each,
// a fix stage, a wrap stage, the divider output register and three sequencer
// stages. A stalled result holds the sequencer; the divider and the input are
// held only while the sequencer is busy and the divider output is valid.
//------------------------------------------------------------------------------
// spatial_hash_neighbor_keys_unit
// Spatial hash grid neighbor bucket key generator, top level.
//------------------------------------------------------------------------------
module spatial_hash_neighbor_keys_unit
    import shnk_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // pos_x [31:0], pos_y [63:32], pos_z [95:64]
    input  logic [95:0]         s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // bucket_key [29:0], corner [32:30], zero fill [39:33]
    output logic [39:0]         m_axis_tdata,
    output logic                m_axis_tlast
);

    t_cfg                r_cfg;
    logic                en;
    logic                dv;
    t_keyset             dk;
    logic                busy;
    logic [KeyW-1:0]     key;
    logic [CornerW-1:0]  cor;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.three_d   <= 1'b1;
            r_cfg.cell_size <= CellW'(65536);
            r_cfg.res_x     <= ResW'(64);
            r_cfg.res_y     <= ResW'(64);
            r_cfg.res_z     <= ResW'(64);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                RegDims: r_cfg.three_d   <= (i_cfg_data[1:0] == 2'd3);
                RegCell: r_cfg.cell_size <= i_cfg_data[CellW-1:0];
                RegResX: r_cfg.res_x     <= i_cfg_data[ResW-1:0];
                RegResY: r_cfg.res_y     <= i_cfg_data[ResW-1:0];
                RegResZ: r_cfg.res_z     <= i_cfg_data[ResW-1:0];
                default: ;
            endcase
        end
    end

    // The divider pipeline advances whenever its output slot is free.
    assign en            = !(dv && busy);
    assign s_axis_tready = en;

    shnk_axis_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_pos   (s_axis_tdata),
        .i_cfg   (r_cfg),
        .o_valid (dv),
        .o_keys  (dk)
    );

    shnk_key_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (dv),
        .i_keys   (dk),
        .i_res_x  ((r_cfg.res_x == '0) ? ResW'(1) :
                   (r_cfg.res_x > ResW'(MaxRes)) ? ResW'(MaxRes) : r_cfg.res_x),
        .i_res_y  ((r_cfg.res_y == '0) ? ResW'(1) :
                   (r_cfg.res_y > ResW'(MaxRes)) ? ResW'(MaxRes) : r_cfg.res_y),
        .o_busy   (busy),
        .o_valid  (m_axis_tvalid),
        .o_key    (key),
        .o_corner (cor),
        .o_last   (m_axis_tlast),
        .i_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {7'd0, cor, key};

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");
    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> (cor == 3'd3 || cor == 3'd7))
        else $error("last key on wrong corner");
    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(dk))
        else $error("divider output moved while stalled");
`endif

endmodule
